### rtl/imt_pkg.sv
// Shared types and constants for the integer multiset table.
package imt_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int FUNC_W   = 2;
    localparam int ST_W     = 2;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 64;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 2'd0,
        FN_QUERY  = 2'd1,
        FN_REMOVE = 2'd2
    } func_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture the request
        logic scan_start;  // rewind the slot scan
        logic scan;        // advance the slot scan
        logic finish;      // commit the operation, latch the result
        logic push;        // move the result into the output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hit;         // compare stage found the wanted slot
        logic miss_end;    // compare stage passed the last slot, no hit
        logic out_free;    // output register can take a result this cycle
    } sts_t;

endpackage

### rtl/imt_ctrl.sv
// Controller state machine: accept, scan, commit, hand off the result.
module imt_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output imt_pkg::cmd_t cmd,
    input  imt_pkg::sts_t sts
);
    import imt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_PUSH = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        s_tready       = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load       = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (sts.hit || sts.miss_end) begin
                    cmd.finish = 1'b1;
                    state_next = S_PUSH;
                end else begin
                    cmd.scan = 1'b1;
                end
            end
            S_PUSH: begin
                if (sts.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/imt_dpath.sv
// Datapath: slot memory, used bits, slot scan pipeline, counters, output register.
module imt_dpath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [imt_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [imt_pkg::FUNC_W-1:0]      s_tuser,
    input  imt_pkg::cmd_t                   cmd,
    output imt_pkg::sts_t                   sts,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [imt_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [imt_pkg::ST_W-1:0]        m_tuser
);
    import imt_pkg::*;

    logic [KEY_W-1:0] mem [CAPACITY];

    func_t              func_reg;
    logic [KEY_W-1:0]   key_reg;

    logic [IDX_W-1:0]   issue_idx_reg;
    logic               issue_end_reg;
    logic               cmp_vld_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic               cmp_last_reg;
    logic               cmp_used_reg;
    logic [KEY_W-1:0]   rd_data_reg;

    logic [CAPACITY-1:0] used_reg;
    logic [CAPACITY-1:0] used_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [KEY_W-1:0]   probe_reg;
    logic [KEY_W-1:0]   probe_next;

    status_t            res_st_reg;
    status_t            res_st_next;
    logic [KEY_W-1:0]   res_val_reg;
    logic [KEY_W-1:0]   res_val_next;

    logic               out_vld_reg;
    status_t            out_st_reg;
    logic [KEY_W-1:0]   out_val_reg;
    logic [KEY_W-1:0]   out_probe_reg;

    logic               match;
    logic               issue;
    logic               mem_we;

    assign issue = cmd.scan && !issue_end_reg;

    // what the compare stage is looking for depends on the operation
    always_comb begin
        case (func_reg)
            FN_INSERT: match = !cmp_used_reg;
            FN_QUERY:  match = cmp_used_reg && (rd_data_reg == key_reg);
            FN_REMOVE: match = cmp_used_reg && (rd_data_reg == key_reg);
            default:   match = 1'b0;
        endcase
    end

    assign sts.hit      = cmp_vld_reg && match;
    assign sts.miss_end = cmp_vld_reg && !match && cmp_last_reg;
    assign sts.out_free = !out_vld_reg || m_tready;

    // commit of one operation
    always_comb begin
        used_next    = used_reg;
        count_next   = count_reg;
        probe_next   = probe_reg;
        res_st_next  = ST_NOT_FOUND;
        res_val_next = '0;
        mem_we       = 1'b0;
        case (func_reg)
            FN_INSERT: begin
                if (sts.hit) begin
                    used_next[cmp_idx_reg] = 1'b1;
                    count_next             = count_reg + 1'b1;
                    mem_we                 = 1'b1;
                    res_st_next            = ST_OK;
                end else begin
                    res_st_next = ST_FULL;
                end
            end
            FN_QUERY: begin
                if (count_reg != '0) begin
                    probe_next = probe_reg + 1'b1;
                end
                if (sts.hit) begin
                    res_st_next = ST_OK;
                end
            end
            FN_REMOVE: begin
                if (sts.hit) begin
                    used_next[cmp_idx_reg] = 1'b0;
                    count_next             = count_reg - 1'b1;
                    res_val_next           = rd_data_reg;
                    res_st_next            = ST_OK;
                end
            end
            default: begin
                res_st_next = ST_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish && mem_we) begin
            mem[cmp_idx_reg] <= key_reg;
        end
        if (issue) begin
            rd_data_reg <= mem[issue_idx_reg];
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= func_t'(s_tuser);
            key_reg  <= s_tdata[KEY_W-1:0];
        end
        if (issue) begin
            cmp_idx_reg  <= issue_idx_reg;
            cmp_last_reg <= (issue_idx_reg == LAST_IDX);
            cmp_used_reg <= used_reg[issue_idx_reg];
        end
        if (cmd.finish) begin
            res_st_reg  <= res_st_next;
            res_val_reg <= res_val_next;
        end
        if (cmd.push) begin
            out_st_reg    <= res_st_reg;
            out_val_reg   <= res_val_reg;
            out_probe_reg <= probe_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_idx_reg <= '0;
            issue_end_reg <= 1'b0;
            cmp_vld_reg   <= 1'b0;
            used_reg      <= '0;
            count_reg     <= '0;
            probe_reg     <= '0;
            out_vld_reg   <= 1'b0;
        end else begin
            if (cmd.scan_start) begin
                issue_idx_reg <= '0;
                issue_end_reg <= 1'b0;
                cmp_vld_reg   <= 1'b0;
            end else if (cmd.scan) begin
                cmp_vld_reg <= issue;
                if (issue) begin
                    issue_idx_reg <= issue_idx_reg + 1'b1;
                    issue_end_reg <= (issue_idx_reg == LAST_IDX);
                end
            end else begin
                cmp_vld_reg <= 1'b0;
            end
            if (cmd.finish) begin
                used_reg  <= used_next;
                count_reg <= count_next;
                probe_reg <= probe_next;
            end
            if (cmd.push) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_probe_reg, out_val_reg};
    assign m_tuser  = out_st_reg;

endmodule

### rtl/int_multiset_table.sv
// Top level of the integer multiset table: controller plus datapath.
//
//  port group  | direction | tdata (low bit up)            | tuser (low bit up)
//  s_*         | request   | key[31:0]                     | func[1:0]
//  m_*         | result    | removed_value[31:0],          | status[1:0]
//              |           | probe_total[63:32]            |
//
// From its accept to the next accept, one request passes through the accept cycle,
// a slot scan that reads one memory entry per cycle through the single read port,
// compares each entry once it is registered, stops at the first wanted slot and
// commits there, then a hand-off to the output register.
// Reset (aresetn low, synchronous) clears all used bits, the entry count and the
// probe counter; the slot values are not cleared. A result waiting in the output
// register does not block the next request; only a second finished result waits.
module int_multiset_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [imt_pkg::S_TDATA_W-1:0] s_tdata,   // key[31:0]
    input  logic [imt_pkg::FUNC_W-1:0]    s_tuser,   // func[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [imt_pkg::M_TDATA_W-1:0] m_tdata,   // removed_value[31:0], probe_total[63:32]
    output logic [imt_pkg::ST_W-1:0]      m_tuser    // status[1:0]
);
    import imt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    imt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    imt_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

### rtl/imt_checker.sv
// Port-level checks for the integer multiset table, bound to the top level.
module imt_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [imt_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [imt_pkg::ST_W-1:0]      m_tuser
);
    import imt_pkg::*;

    // no result right after reset
    a_rst_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // one request at a time: an accepted request closes the input
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in work");

    // removed value is zero unless the operation succeeded
    a_rm_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata[KEY_W-1:0] == '0))
        else $error("nonzero removed value on failed operation");

    a_st_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_NOT_FOUND || m_tuser == ST_FULL))
        else $error("unknown status code");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind int_multiset_table imt_checker u_imt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
